// File: hw/rtl/sdspi_pkg.sv
// shared types and constants for the sd spi command engine
`default_nettype none
package sdspi_pkg;
  localparam int BlockBytesDef = 512;
  localparam int MaxResponseDef = 5;

  localparam logic [1:0] OP_CMD = 2'd0;
  localparam logic [1:0] OP_READ = 2'd1;
  localparam logic [1:0] OP_BYTE = 2'd2;

  localparam logic [1:0] ERR_NONE = 2'd0;
  localparam logic [1:0] ERR_RESP = 2'd1;
  localparam logic [1:0] ERR_TOKEN = 2'd2;

  localparam logic [1:0] KIND_NONE = 2'd0;
  localparam logic [1:0] KIND_RESP = 2'd1;
  localparam logic [1:0] KIND_DATA = 2'd2;

  // work kinds passed from front to back
  localparam logic [2:0] JOB_SEND = 3'd0;   // send mosi byte with optional rx
  localparam logic [2:0] JOB_NOSEND = 3'd1; // rx only, no mosi
  localparam logic [2:0] JOB_IDLE4 = 3'd2;  // four idle bytes then finish ok
  localparam logic [2:0] JOB_FIN = 3'd3;    // finish with error code
  localparam logic [2:0] JOB_CMD = 3'd4;    // full command burst

  typedef struct packed {
    logic [2:0]  job;
    logic [7:0]  mosi;
    logic [7:0]  rx;
    logic [1:0]  kind;
    logic [1:0]  err;
    logic [7:0]  status;
    logic        hold;      // keep selected on success
    logic        more;      // another job of the same item follows
    logic [39:0] cmd;       // command byte and argument
    logic [7:0]  crcb;
  } job_t;

  function automatic logic [6:0] crc7_byte(input logic [6:0] crc, input logic [7:0] data);
    logic [6:0] c;
    logic       fb;
    c = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = c[6] ^ data[i];
      c = {c[5:0], 1'b0};
      if (fb) c = c ^ 7'h09;
    end
    return c;
  endfunction
endpackage
`default_nettype wire

// File: hw/rtl/sd_spi_command_engine.sv
// top level of the sd card spi command engine
// an accepted item passes through the job queue and then the output register
// one result item per cycle while out_stall is low; a command request expands into seven items
// a card byte item enters every cycle while the four-entry job queue has room for two
// reset (rst_n low, synchronous) deselects the card, returns to idle, crc off, poll limit 16
`default_nettype none
module sd_spi_command_engine #(
  parameter int BLOCK_BYTES = sdspi_pkg::BlockBytesDef,
  parameter int MAX_RESPONSE = sdspi_pkg::MaxResponseDef
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire [2:0]   paddr,
  input  wire [31:0]  pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  wire         in_valid,
  output logic        in_stall,
  input  wire [1:0]   in_opcode,
  input  wire [5:0]   in_cmd_index,
  input  wire [31:0]  in_cmd_argument,
  input  wire         in_keep_selected,
  input  wire [2:0]   in_response_bytes,
  input  wire [9:0]   in_read_count,
  input  wire [7:0]   in_card_byte,
  output logic        out_valid,
  input  wire         out_stall,
  output logic [7:0]  out_mosi_byte,
  output logic        out_mosi_valid,
  output logic        out_card_select,
  output logic [7:0]  out_rx_byte,
  output logic [1:0]  out_rx_kind,
  output logic [7:0]  out_status_byte,
  output logic [1:0]  out_error_code,
  output logic        out_done_res,
  output logic        out_last
);
  import sdspi_pkg::*;

  localparam logic [2:0] ADDR_CRC = 3'd0;
  localparam logic [2:0] ADDR_POLL = 3'd4;

  logic       crc_en_r;
  logic [7:0] poll_r;
  logic       wr;
  job_t       j1, j2, head;
  logic       p1, p2, room2, nempty, pop;

  // config registers
  assign pready = 1'b1;
  assign wr = psel && penable && pwrite;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_en_r <= 1'b0;
      poll_r <= 8'd16;
    end else if (wr) begin
      if (paddr == ADDR_CRC) crc_en_r <= pwdata[0];
      if (paddr == ADDR_POLL) poll_r <= pwdata[7:0];
    end
  end
  always_comb begin
    prdata = 32'd0;
    if (paddr == ADDR_CRC) prdata = {31'd0, crc_en_r};
    else if (paddr == ADDR_POLL) prdata = {24'd0, poll_r};
  end

  // front: protocol state, turns each item into jobs
  sdspi_front #(.BLOCK_BYTES(BLOCK_BYTES), .MAX_RESPONSE(MAX_RESPONSE)) u_front (
    .clk(clk), .rst_n(rst_n), .crc_enable(crc_en_r), .poll_limit(poll_r),
    .in_valid(in_valid), .in_stall(in_stall), .in_opcode(in_opcode),
    .in_cmd_index(in_cmd_index), .in_cmd_argument(in_cmd_argument),
    .in_keep_selected(in_keep_selected), .in_response_bytes(in_response_bytes),
    .in_read_count(in_read_count), .in_card_byte(in_card_byte),
    .q_push(p1), .q_data(j1), .q_push2(p2), .q_data2(j2), .q_room2(room2)
  );

  // decoupling queue
  sdspi_queue #(.DEPTH(4)) u_queue (
    .clk(clk), .rst_n(rst_n), .push(p1), .push_data(j1), .push2(p2),
    .push_data2(j2), .room2(room2), .not_empty(nempty), .head(head), .pop(pop)
  );

  // back: emits result items from the output register
  sdspi_back u_back (
    .clk(clk), .rst_n(rst_n), .q_not_empty(nempty), .q_head(head), .q_pop(pop),
    .out_valid(out_valid), .out_stall(out_stall), .out_mosi_byte(out_mosi_byte),
    .out_mosi_valid(out_mosi_valid), .out_card_select(out_card_select),
    .out_rx_byte(out_rx_byte), .out_rx_kind(out_rx_kind),
    .out_status_byte(out_status_byte), .out_error_code(out_error_code),
    .out_done_res(out_done_res), .out_last(out_last)
  );
endmodule
`default_nettype wire

// File: hw/rtl/sdspi_front.sv
// front part: protocol state, classifies each item into back jobs
`default_nettype none
module sdspi_front #(
  parameter int BLOCK_BYTES = sdspi_pkg::BlockBytesDef,
  parameter int MAX_RESPONSE = sdspi_pkg::MaxResponseDef
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 crc_enable,
  input  wire [7:0]           poll_limit,
  input  wire                 in_valid,
  output logic                in_stall,
  input  wire [1:0]           in_opcode,
  input  wire [5:0]           in_cmd_index,
  input  wire [31:0]          in_cmd_argument,
  input  wire                 in_keep_selected,
  input  wire [2:0]           in_response_bytes,
  input  wire [9:0]           in_read_count,
  input  wire [7:0]           in_card_byte,
  output logic                q_push,
  output sdspi_pkg::job_t     q_data,
  output logic                q_push2,
  output sdspi_pkg::job_t     q_data2,
  input  wire                 q_room2
);
  import sdspi_pkg::*;

  localparam logic [2:0] PH_IDLE = 3'd0;
  localparam logic [2:0] PH_R1 = 3'd1;
  localparam logic [2:0] PH_RESP = 3'd2;
  localparam logic [2:0] PH_TOKEN = 3'd3;
  localparam logic [2:0] PH_DATA = 3'd4;
  localparam int DW = $clog2(BLOCK_BYTES + 1);
  localparam int RW = $clog2(MAX_RESPONSE + 1);

  logic [2:0]    phase_r, phase_nxt;
  logic [7:0]    polls_r, polls_nxt;
  logic [RW-1:0] resp_r, resp_nxt;
  logic [DW-1:0] data_r, data_nxt;
  logic [7:0]    status_r, status_nxt;
  logic          hold_r, hold_nxt;
  logic          rdp_r, rdp_nxt;

  logic          acc;
  logic [7:0]    lim;
  logic [7:0]    pl;
  logic [RW-1:0] rl;
  logic [DW-1:0] dc;
  logic [7:0]    cmd;
  logic [6:0]    crc;
  logic [7:0]    crcb;
  logic [7:0]    b;
  job_t          j1, j2;
  logic          p1, p2;

  assign in_stall = !q_room2;
  assign acc = in_valid && q_room2;
  assign lim = (poll_limit == 8'd0) ? 8'd1 : poll_limit;
  assign b = in_card_byte;
  assign cmd = {2'b01, in_cmd_index};

  always_comb begin
    crc = crc7_byte(7'd0, cmd);
    crc = crc7_byte(crc, in_cmd_argument[31:24]);
    crc = crc7_byte(crc, in_cmd_argument[23:16]);
    crc = crc7_byte(crc, in_cmd_argument[15:8]);
    crc = crc7_byte(crc, in_cmd_argument[7:0]);
  end

  always_comb begin
    if (crc_enable) crcb = {crc, 1'b1};
    else if (in_cmd_index == 6'd0) crcb = 8'h95;
    else if (in_cmd_index == 6'd8) crcb = 8'h69;
    else crcb = 8'h00;
  end

  always_comb begin
    if (in_response_bytes == 3'd0) rl = RW'(1);
    else if (int'(in_response_bytes) > MAX_RESPONSE) rl = RW'(MAX_RESPONSE);
    else rl = RW'(in_response_bytes);
    if (int'(in_read_count) > BLOCK_BYTES) dc = DW'(BLOCK_BYTES);
    else dc = DW'(in_read_count);
  end

  always_comb begin
    logic [RW-1:0] rd;
    logic [DW-1:0] dd;
    phase_nxt = phase_r;
    polls_nxt = polls_r;
    resp_nxt = resp_r;
    data_nxt = data_r;
    status_nxt = status_r;
    hold_nxt = hold_r;
    rdp_nxt = rdp_r;
    pl = (polls_r > 8'd0) ? polls_r - 8'd1 : 8'd0;
    rd = (resp_r > RW'(0)) ? resp_r - RW'(1) : RW'(0);
    dd = (data_r > DW'(0)) ? data_r - DW'(1) : DW'(0);
    p1 = 1'b0;
    p2 = 1'b0;
    j1 = '0;
    j2 = '0;
    j1.job = JOB_SEND;
    j1.mosi = 8'hFF;
    j1.hold = hold_r;
    j1.status = status_r;
    j2 = j1;
    if (acc) begin
      if ((in_opcode == OP_CMD || in_opcode == OP_READ) && phase_r == PH_IDLE) begin
        p1 = 1'b1;
        j1.job = JOB_CMD;
        j1.cmd = {cmd, in_cmd_argument};
        j1.crcb = crcb;
        j1.status = 8'd0;
        status_nxt = 8'd0;
        hold_nxt = in_keep_selected;
        rdp_nxt = (in_opcode == OP_READ);
        resp_nxt = rl - RW'(1);
        data_nxt = (in_opcode == OP_READ) ? dc : DW'(0);
        polls_nxt = lim;
        phase_nxt = PH_R1;
      end else if (in_opcode == OP_BYTE) begin
        unique case (phase_r)
          PH_R1: begin
            polls_nxt = pl;
            p1 = 1'b1;
            if (!b[7]) begin
              status_nxt = b;
              j1.status = b;
              if (resp_r > RW'(0)) begin
                phase_nxt = PH_RESP;
              end else if (rdp_r) begin
                phase_nxt = PH_TOKEN;
                polls_nxt = lim;
              end else begin
                j1.job = JOB_FIN;
                phase_nxt = PH_IDLE;
              end
            end else if (pl == 8'd0) begin
              status_nxt = b;
              j1.status = b;
              j1.job = JOB_FIN;
              j1.err = ERR_RESP;
              phase_nxt = PH_IDLE;
            end
          end
          PH_RESP: begin
            resp_nxt = rd;
            p1 = 1'b1;
            j1.rx = b;
            j1.kind = KIND_RESP;
            if (rd == RW'(0)) begin
              j1.job = JOB_NOSEND;
              j1.more = 1'b1;
              p2 = 1'b1;
              if (rdp_r) begin
                phase_nxt = PH_TOKEN;
                polls_nxt = lim;
              end else begin
                j2.job = JOB_FIN;
                phase_nxt = PH_IDLE;
              end
            end
          end
          PH_TOKEN: begin
            polls_nxt = pl;
            p1 = 1'b1;
            if (b == 8'hFE) begin
              if (data_r > DW'(0)) phase_nxt = PH_DATA;
              else begin
                j1.job = JOB_IDLE4;
                phase_nxt = PH_IDLE;
              end
            end else if (pl == 8'd0) begin
              j1.job = JOB_FIN;
              j1.err = ERR_TOKEN;
              phase_nxt = PH_IDLE;
            end
          end
          PH_DATA: begin
            data_nxt = dd;
            p1 = 1'b1;
            j1.rx = b;
            j1.kind = KIND_DATA;
            if (dd == DW'(0)) begin
              j1.job = JOB_NOSEND;
              j1.more = 1'b1;
              p2 = 1'b1;
              j2.job = JOB_IDLE4;
              phase_nxt = PH_IDLE;
            end
          end
          default: ;
        endcase
      end
      if (phase_nxt == PH_IDLE) begin
        polls_nxt = 8'd0;
        resp_nxt = RW'(0);
        data_nxt = DW'(0);
        rdp_nxt = 1'b0;
      end
    end
  end

  assign q_push = p1;
  assign q_data = j1;
  assign q_push2 = p2;
  assign q_data2 = j2;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      polls_r <= 8'd0;
      resp_r <= RW'(0);
      data_r <= DW'(0);
      status_r <= 8'd0;
      hold_r <= 1'b0;
      rdp_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      polls_r <= polls_nxt;
      resp_r <= resp_nxt;
      data_r <= data_nxt;
      status_r <= status_nxt;
      hold_r <= hold_nxt;
      rdp_r <= rdp_nxt;
    end
  end
endmodule
`default_nettype wire

// File: hw/rtl/sdspi_queue.sv
// short job queue between front and back, takes up to two jobs a cycle
`default_nettype none
module sdspi_queue #(
  parameter int DEPTH = 4
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 push,
  input  sdspi_pkg::job_t     push_data,
  input  wire                 push2,
  input  sdspi_pkg::job_t     push_data2,
  output logic                room2,
  output logic                not_empty,
  output sdspi_pkg::job_t     head,
  input  wire                 pop
);
  import sdspi_pkg::*;
  localparam int AW = $clog2(DEPTH);

  job_t        mem_r [DEPTH];
  logic [AW-1:0] wp_r, rp_r;
  logic [AW:0]   cnt_r;
  logic [AW:0]   np;
  logic          dp;

  assign np = {AW'(0), push} + {AW'(0), push2};
  assign dp = pop && not_empty;
  assign room2 = (cnt_r + (AW+1)'(2)) <= (AW+1)'(DEPTH);
  assign not_empty = cnt_r != '0;
  assign head = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_data;
    if (push2) mem_r[wp_r + AW'(1)] <= push_data2;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      wp_r <= wp_r + np[AW-1:0];
      if (dp) rp_r <= rp_r + AW'(1);
      cnt_r <= cnt_r + np - {AW'(0), dp};
    end
  end
endmodule
`default_nettype wire

// File: hw/rtl/sdspi_back.sv
// back part: expands jobs into result items, tracks card select
`default_nettype none
module sdspi_back (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 q_not_empty,
  input  sdspi_pkg::job_t     q_head,
  output logic                q_pop,
  output logic                out_valid,
  input  wire                 out_stall,
  output logic [7:0]          out_mosi_byte,
  output logic                out_mosi_valid,
  output logic                out_card_select,
  output logic [7:0]          out_rx_byte,
  output logic [1:0]          out_rx_kind,
  output logic [7:0]          out_status_byte,
  output logic [1:0]          out_error_code,
  output logic                out_done_res,
  output logic                out_last
);
  import sdspi_pkg::*;

  logic [2:0] step_r, step_nxt;
  logic       sel_r, sel_nxt;
  logic       ov_r;
  logic [7:0] mb_r, rx_r, st_r, mb;
  logic       mv_r, cs_r, dn_r, ls_r, mv, dn, ls, fin_drop;
  logic [1:0] rk_r, er_r;
  logic       load, endjob;
  logic [2:0] nsteps;

  assign load = q_not_empty && (!ov_r || !out_stall);

  // number of items minus one per job
  always_comb begin
    fin_drop = !q_head.hold || q_head.err != ERR_NONE;
    unique case (q_head.job)
      JOB_CMD:   nsteps = 3'd6;
      JOB_IDLE4: nsteps = fin_drop ? 3'd5 : 3'd4;
      JOB_FIN:   nsteps = fin_drop ? 3'd1 : 3'd0;
      default:   nsteps = 3'd0;
    endcase
  end

  assign endjob = step_r == nsteps;
  assign q_pop = load && endjob;

  always_comb begin
    logic fin_seg;
    mb = 8'hFF;
    mv = 1'b1;
    dn = 1'b0;
    sel_nxt = sel_r;
    step_nxt = endjob ? 3'd0 : step_r + 3'd1;
    fin_seg = 1'b0;
    unique case (q_head.job)
      JOB_CMD: begin
        sel_nxt = 1'b1;
        unique case (step_r)
          3'd0: mb = q_head.cmd[39:32];
          3'd1: mb = q_head.cmd[31:24];
          3'd2: mb = q_head.cmd[23:16];
          3'd3: mb = q_head.cmd[15:8];
          3'd4: mb = q_head.cmd[7:0];
          3'd5: mb = q_head.crcb;
          default: mb = 8'hFF;
        endcase
      end
      JOB_SEND: mb = q_head.mosi;
      JOB_NOSEND: mv = 1'b0;
      JOB_IDLE4: fin_seg = step_r >= 3'd4;
      JOB_FIN: fin_seg = 1'b1;
      default: ;
    endcase
    if (fin_seg) begin
      if (fin_drop) sel_nxt = 1'b0;
      else mv = 1'b0;
      dn = endjob;
    end
    ls = endjob && !q_head.more;
  end

  always_ff @(posedge clk) begin
    if (load) begin
      mb_r <= mv ? mb : 8'd0;
      mv_r <= mv;
      cs_r <= sel_nxt;
      rx_r <= q_head.rx;
      rk_r <= q_head.kind;
      st_r <= q_head.status;
      er_r <= dn ? q_head.err : ERR_NONE;
      dn_r <= dn;
      ls_r <= ls;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
      step_r <= 3'd0;
      sel_r <= 1'b0;
    end else begin
      if (load) begin
        ov_r <= 1'b1;
        step_r <= step_nxt;
        sel_r <= sel_nxt;
      end else if (!out_stall) begin
        ov_r <= 1'b0;
      end
    end
  end

  assign out_valid = ov_r;
  assign out_mosi_byte = mb_r;
  assign out_mosi_valid = mv_r;
  assign out_card_select = cs_r;
  assign out_rx_byte = rx_r;
  assign out_rx_kind = rk_r;
  assign out_status_byte = st_r;
  assign out_error_code = er_r;
  assign out_done_res = dn_r;
  assign out_last = ls_r;
endmodule
`default_nettype wire
